// ===== src/sme_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stack machine execute unit.
// ---------------------------------------------------------------------------
package sme_pkg;

	localparam int DEF_STACK_DEPTH = 4096;
	localparam int DEF_VAR_COUNT   = 4096;
	localparam int PROGRAM_WORDS   = 65536;
	localparam int IDX_W           = $clog2(PROGRAM_WORDS);
	localparam int DATA_W          = 64;

	// opcodes
	localparam logic [7:0] OP_END  = 8'd0;
	localparam logic [7:0] OP_PUSH = 8'd1;
	localparam logic [7:0] OP_ADD  = 8'd2;
	localparam logic [7:0] OP_SUB  = 8'd3;
	localparam logic [7:0] OP_MUL  = 8'd4;
	localparam logic [7:0] OP_DIV  = 8'd5;
	localparam logic [7:0] OP_STORE = 8'd6;
	localparam logic [7:0] OP_LOAD = 8'd7;
	localparam logic [7:0] OP_PRINT = 8'd8;
	localparam logic [7:0] OP_NEG  = 8'd9;
	localparam logic [7:0] OP_GT   = 8'd10;
	localparam logic [7:0] OP_LT   = 8'd11;
	localparam logic [7:0] OP_JT   = 8'd12;
	localparam logic [7:0] OP_JF   = 8'd13;
	localparam logic [7:0] OP_JMP  = 8'd14;
	localparam logic [7:0] OP_MOD  = 8'd15;
	localparam logic [7:0] OP_EQ   = 8'd16;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
	localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
	localparam logic [2:0] ERR_VAR_INDEX = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_COMMIT
	} sme_state_t;

endpackage
`default_nettype wire

// ===== src/sme_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sme_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/stack_machine_execute_unit.sv =====
`default_nettype none
// The result word is registered at commit; mul takes three passes of a 32x32 multiplier,
// div and mod take one quotient bit a cycle, and commit waits for the result register
// to drain.
// One instruction at a time; the next word is taken the cycle after commit.
// Reset: after arst_n the variable store is swept to zero, during which no word is
// taken; the operand stack itself is not cleared.
// ---------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack machine instruction per input word; top of stack is cached
// in a register, the rest of the stack and the variables sit in RAM.
// ---------------------------------------------------------------------------
module stack_machine_execute_unit
	import sme_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VAR_COUNT   = DEF_VAR_COUNT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire logic [7:0]               func,
	input  wire logic signed [DATA_W-1:0] operand,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic [IDX_W-1:0]              next_index,
	output logic                          print_valid,
	output logic signed [DATA_W-1:0]      print_value,
	output logic signed [DATA_W-1:0]      top_value,
	output logic                          halted,
	output logic [2:0]                    error_code
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int VAW = $clog2(VAR_COUNT);

	sme_state_t state_q, next_state;

	logic [SPW-1:0]    sp_q;
	logic [DATA_W-1:0] top_q;
	logic [IDX_W-1:0]  pi_q;
	logic              halt_q;
	logic [7:0]        func_q;
	logic [DATA_W-1:0] opnd_q;
	logic [VAW-1:0]    clr_q;

	logic [DATA_W-1:0] srd, vrd;
	logic              s_we, v_we;
	logic [SAW-1:0]    s_waddr, s_raddr;
	logic [VAW-1:0]    v_waddr, v_raddr;
	logic [DATA_W-1:0] s_wdata;

	// multiply and divide units
	logic [1:0]        mstep_q;
	logic [DATA_W-1:0] acc_q;
	logic [31:0]       mul_x, mul_y;
	logic [63:0]       mul_p;
	logic [DATA_W-1:0] quo_q, rem_q, mag_b_q;
	logic [6:0]        dcnt_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] mag_a, mag_b;

	// decode and checks
	logic              is_bin, is_pop1, need_mul, need_div, var_bad, sp_full;
	logic              start_mul, start_div, out_free, commit;
	logic [2:0]        err_c;
	logic [DATA_W-1:0] r_fast, r_bin, pop_top;
	logic [IDX_W-1:0]  pi_p1, pi_p2, tgt;

	// commit values
	logic [SPW-1:0]    n_sp;
	logic [DATA_W-1:0] n_top;
	logic [IDX_W-1:0]  n_pi;
	logic              n_halt, n_pv;
	logic [DATA_W-1:0] n_pval;
	logic              vst_we;

	// memories
	sme_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(srd)
	);

	sme_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_var_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr),
		.wdata((state_q == ST_CLEAR) ? '0 : top_q),
		.raddr(v_raddr), .rdata(vrd)
	);

	assign s_raddr = SAW'(sp_q - SPW'(2));
	assign v_raddr = (state_q == ST_IDLE) ? operand[VAW-1:0] : opnd_q[VAW-1:0];

	// decode
	assign is_bin = (func_q == OP_ADD) || (func_q == OP_SUB) || (func_q == OP_MUL) ||
		(func_q == OP_DIV) || (func_q == OP_GT) || (func_q == OP_LT) ||
		(func_q == OP_MOD) || (func_q == OP_EQ);
	assign is_pop1 = (func_q == OP_PRINT) || (func_q == OP_NEG) ||
		(func_q == OP_JT) || (func_q == OP_JF) || (func_q == OP_STORE);
	assign need_mul = (func_q == OP_MUL);
	assign need_div = (func_q == OP_DIV) || (func_q == OP_MOD);
	assign var_bad  = (opnd_q >= DATA_W'(VAR_COUNT));
	assign sp_full  = (sp_q == SPW'(STACK_DEPTH));

	// error check
	always_comb begin
		err_c = ERR_NONE;
		if (is_bin) begin
			if (sp_q < SPW'(2)) begin
				err_c = ERR_UNDERFLOW;
			end else if (need_div && top_q == '0) begin
				err_c = ERR_DIV_ZERO;
			end
		end else if (is_pop1) begin
			if (sp_q == '0) begin
				err_c = ERR_UNDERFLOW;
			end else if (func_q == OP_STORE && var_bad) begin
				err_c = ERR_VAR_INDEX;
			end
		end else if (func_q == OP_LOAD) begin
			if (var_bad) begin
				err_c = ERR_VAR_INDEX;
			end else if (sp_full) begin
				err_c = ERR_OVERFLOW;
			end
		end else if (func_q == OP_PUSH && sp_full) begin
			err_c = ERR_OVERFLOW;
		end
	end

	assign out_free  = !result_valid || !result_stall;
	assign start_mul = (state_q == ST_EXEC) && !halt_q && err_c == ERR_NONE && need_mul;
	assign start_div = (state_q == ST_EXEC) && !halt_q && err_c == ERR_NONE && need_div;
	assign commit    = out_free && ((state_q == ST_COMMIT) ||
		(state_q == ST_EXEC && !start_mul && !start_div));

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == VAW'(VAR_COUNT - 1)) next_state = ST_IDLE;
			ST_IDLE:   if (item_valid) next_state = ST_EXEC;
			ST_EXEC: begin
				if (start_mul) next_state = ST_MUL;
				else if (start_div) next_state = ST_DIV;
				else if (out_free) next_state = ST_IDLE;
			end
			ST_MUL:    if (mstep_q == 2'd2) next_state = ST_COMMIT;
			ST_DIV:    if (dcnt_q == 7'd1) next_state = ST_COMMIT;
			ST_COMMIT: if (out_free) next_state = ST_IDLE;
			default:   next_state = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		item_stall = (state_q != ST_IDLE);
	end

	// multiplier operand select, one 32x32 product per cycle
	always_comb begin
		case (mstep_q)
			2'd0:    begin mul_x = srd[31:0];  mul_y = top_q[31:0];  end
			2'd1:    begin mul_x = srd[31:0];  mul_y = top_q[63:32]; end
			default: begin mul_x = srd[63:32]; mul_y = top_q[31:0];  end
		endcase
		mul_p = 64'(mul_x) * 64'(mul_y);
	end

	// divider magnitudes and trial subtract
	assign mag_a = srd[63] ? (DATA_W'(0) - srd) : srd;
	assign mag_b = top_q[63] ? (DATA_W'(0) - top_q) : top_q;
	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, mag_b_q};

	// single-cycle alu and result select
	always_comb begin
		case (func_q)
			OP_ADD:  r_fast = srd + top_q;
			OP_SUB:  r_fast = srd - top_q;
			OP_GT:   r_fast = DATA_W'($signed(srd) > $signed(top_q));
			OP_LT:   r_fast = DATA_W'($signed(srd) < $signed(top_q));
			default: r_fast = DATA_W'(srd == top_q);
		endcase
		case (func_q)
			OP_MUL:  r_bin = acc_q;
			OP_DIV:  r_bin = (srd[63] ^ top_q[63]) ? (DATA_W'(0) - quo_q) : quo_q;
			OP_MOD:  r_bin = srd[63] ? (DATA_W'(0) - rem_q) : rem_q;
			default: r_bin = r_fast;
		endcase
	end

	assign pop_top = (sp_q >= SPW'(2)) ? srd : '0;
	assign pi_p1   = pi_q + IDX_W'(1);
	assign pi_p2   = pi_q + IDX_W'(2);
	assign tgt     = opnd_q[IDX_W-1:0] + IDX_W'(1);

	// instruction effect
	always_comb begin
		n_sp    = sp_q;
		n_top   = top_q;
		n_pi    = pi_p1;
		n_halt  = halt_q;
		n_pv    = 1'b0;
		n_pval  = '0;
		s_we    = 1'b0;
		s_wdata = top_q;
		vst_we  = 1'b0;
		if (halt_q) begin
			n_pi = pi_q;
		end else if (err_c != ERR_NONE) begin
			n_pi   = pi_q;
			n_halt = 1'b1;
		end else begin
			case (func_q)
				OP_END: begin
					n_pi   = pi_q;
					n_halt = 1'b1;
				end
				OP_PUSH, OP_LOAD: begin
					s_we  = commit && (sp_q != '0);
					n_top = (func_q == OP_PUSH) ? opnd_q : vrd;
					n_sp  = sp_q + SPW'(1);
					n_pi  = pi_p2;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_MOD, OP_EQ: begin
					n_top = r_bin;
					n_sp  = sp_q - SPW'(1);
				end
				OP_STORE: begin
					vst_we = 1'b1;
					n_top  = pop_top;
					n_sp   = sp_q - SPW'(1);
					n_pi   = pi_p2;
				end
				OP_PRINT: begin
					n_pv   = 1'b1;
					n_pval = top_q;
					n_top  = pop_top;
					n_sp   = sp_q - SPW'(1);
				end
				OP_NEG: n_top = DATA_W'(0) - top_q;
				OP_JT, OP_JF: begin
					n_top = pop_top;
					n_sp  = sp_q - SPW'(1);
					n_pi  = (((func_q == OP_JT)) == (top_q != '0)) ? tgt : pi_p2;
				end
				OP_JMP: n_pi = tgt;
				default: ;
			endcase
		end
	end

	assign s_waddr = SAW'(sp_q - SPW'(1));
	assign v_we    = (state_q == ST_CLEAR) || (commit && vst_we);
	assign v_waddr = (state_q == ST_CLEAR) ? clr_q : opnd_q[VAW-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			sp_q         <= '0;
			pi_q         <= '0;
			halt_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= next_state;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + VAW'(1);
			end
			if (commit) begin
				sp_q         <= n_sp;
				pi_q         <= n_pi;
				halt_q       <= n_halt;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			func_q <= func;
			opnd_q <= operand;
		end
		if (commit) begin
			top_q       <= n_top;
			next_index  <= n_pi;
			print_valid <= n_pv;
			print_value <= n_pval;
			top_value   <= (n_sp == '0) ? '0 : n_top;
			halted      <= n_halt;
			error_code  <= halt_q ? ERR_NONE : err_c;
		end
		// multiply sequencer
		if (start_mul) begin
			mstep_q <= 2'd0;
			acc_q   <= '0;
		end else if (state_q == ST_MUL) begin
			mstep_q <= mstep_q + 2'd1;
			acc_q   <= acc_q + ((mstep_q == 2'd0) ? mul_p : {mul_p[31:0], 32'd0});
		end
		// restoring divider, one bit a cycle
		if (start_div) begin
			quo_q   <= mag_a;
			rem_q   <= '0;
			mag_b_q <= mag_b;
			dcnt_q  <= 7'(DATA_W);
		end else if (state_q == ST_DIV) begin
			dcnt_q <= dcnt_q - 7'd1;
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Testbench of the stack machine execute unit: instructions go in as words,
// and a behavioral copy of the machine predicts every result word, which is
// checked field by field as it leaves the block. Reset is applied only once,
// and a halt is permanent, so the run ends with one chosen halting case.
// ---------------------------------------------------------------------------
module tb
	import sme_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// small stack so that filling it for the overflow case stays short
	localparam int DEPTH = 128;
	localparam int NVARS = DEF_VAR_COUNT;
	localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             pv;
		logic [63:0]      pval;
		logic [63:0]      top;
		logic             hlt;
		logic [2:0]       err;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [7:0] func = 8'd0;
	logic signed [63:0] operand = 64'sd0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [IDX_W-1:0] next_index;
	logic print_valid;
	logic signed [63:0] print_value;
	logic signed [63:0] top_value;
	logic halted;
	logic [2:0] error_code;

	int send_idle = 35;
	int recv_idle = 35;
	int errors = 0;
	exec_result_t expected_q[$];

	// machine copy used for prediction
	logic [63:0] m_stack [DEPTH];
	logic [63:0] m_vars [NVARS];
	int m_sp = 0;
	int m_pc = 0;
	bit m_halt = 1'b0;

	always #1 clk = ~clk;

	stack_machine_execute_unit #(.STACK_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .operand(operand),
		.result_valid(result_valid), .result_stall(result_stall),
		.next_index(next_index), .print_valid(print_valid), .print_value(print_value),
		.top_value(top_value), .halted(halted), .error_code(error_code)
	);

	// signed magnitude helpers for truncating division
	function automatic logic [63:0] mag(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// execute one instruction on the machine copy
	function automatic exec_result_t execute_insn(input logic [7:0] f, input logic [63:0] o);
		exec_result_t r;
		int nxt;
		logic [2:0] err;
		logic [63:0] a, b, q;
		nxt = m_pc;
		err = ERR_NONE;
		r = '0;
		if (!m_halt) begin
			nxt = (m_pc + 1) % PROGRAM_WORDS;
			case (f)
				OP_END: begin
					m_halt = 1'b1;
					nxt = m_pc;
				end
				OP_PUSH: begin
					if (m_sp >= DEPTH) err = ERR_OVERFLOW;
					else begin
						m_stack[m_sp] = o;
						m_sp++;
						nxt = (m_pc + 2) % PROGRAM_WORDS;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_MOD, OP_EQ: begin
					if (m_sp < 2) err = ERR_UNDERFLOW;
					else begin
						a = m_stack[m_sp-2];
						b = m_stack[m_sp-1];
						if ((f == OP_DIV || f == OP_MOD) && b == 0) err = ERR_DIV_ZERO;
						else begin
							case (f)
								OP_ADD: q = a + b;
								OP_SUB: q = a - b;
								OP_MUL: q = a * b;
								OP_DIV: begin
									q = mag(a) / mag(b);
									if (a[63] ^ b[63]) q = 64'd0 - q;
								end
								OP_MOD: begin
									q = mag(a) % mag(b);
									if (a[63]) q = 64'd0 - q;
								end
								OP_GT: q = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
								OP_LT: q = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
								default: q = (a == b) ? 64'd1 : 64'd0;
							endcase
							m_stack[m_sp-2] = q;
							m_sp--;
						end
					end
				end
				OP_STORE: begin
					if (m_sp < 1) err = ERR_UNDERFLOW;
					else if (o >= NVARS) err = ERR_VAR_INDEX;
					else begin
						m_vars[o] = m_stack[m_sp-1];
						m_sp--;
						nxt = (m_pc + 2) % PROGRAM_WORDS;
					end
				end
				OP_LOAD: begin
					if (o >= NVARS) err = ERR_VAR_INDEX;
					else if (m_sp >= DEPTH) err = ERR_OVERFLOW;
					else begin
						m_stack[m_sp] = m_vars[o];
						m_sp++;
						nxt = (m_pc + 2) % PROGRAM_WORDS;
					end
				end
				OP_PRINT: begin
					if (m_sp < 1) err = ERR_UNDERFLOW;
					else begin
						r.pv = 1'b1;
						r.pval = m_stack[m_sp-1];
						m_sp--;
					end
				end
				OP_NEG: begin
					if (m_sp < 1) err = ERR_UNDERFLOW;
					else m_stack[m_sp-1] = 64'd0 - m_stack[m_sp-1];
				end
				OP_JT, OP_JF: begin
					if (m_sp < 1) err = ERR_UNDERFLOW;
					else begin
						m_sp--;
						if ((f == OP_JT) == (m_stack[m_sp] != 0)) nxt = int'(o[15:0] + 16'd1);
						else nxt = (m_pc + 2) % PROGRAM_WORDS;
					end
				end
				OP_JMP: nxt = int'(o[15:0] + 16'd1);
				default: ;
			endcase
			if (err != ERR_NONE) begin
				m_halt = 1'b1;
				nxt = m_pc;
			end
			m_pc = nxt;
		end
		r.idx = nxt[IDX_W-1:0];
		r.top = (m_sp == 0) ? 64'd0 : m_stack[m_sp-1];
		r.hlt = m_halt;
		r.err = err;
		return r;
	endfunction

	// send one instruction word, idling at random first
	task automatic send_insn(input logic [7:0] f, input logic [63:0] o);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		func <= f;
		operand <= o;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		expected_q.push_back(execute_insn(f, o));
	endtask

	// receiver stall pattern
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_idle);

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		exec_result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, next_index %0d", $realtime, next_index);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (next_index !== e.idx) begin
					$display("%0t: next_index exp %0d got %0d", $realtime, e.idx, next_index);
					errors++;
				end
				if (print_valid !== e.pv) begin
					$display("%0t: print_valid exp %0d got %0d", $realtime, e.pv, print_valid);
					errors++;
				end
				if (print_value !== e.pval) begin
					$display("%0t: print_value exp %h got %h", $realtime, e.pval, print_value);
					errors++;
				end
				if (top_value !== e.top) begin
					$display("%0t: top_value exp %h got %h", $realtime, e.top, top_value);
					errors++;
				end
				if (halted !== e.hlt) begin
					$display("%0t: halted exp %0d got %0d", $realtime, e.hlt, halted);
					errors++;
				end
				if (error_code !== e.err) begin
					$display("%0t: error_code exp %0d got %0d", $realtime, e.err, error_code);
					errors++;
				end
			end
		end
	end

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return MAXV;
			2: return MINV;
			3: return 64'd0 - 64'($urandom_range(9));
			default: return 64'($urandom_range(20));
		endcase
	endfunction

	function automatic logic [63:0] rand_var();
		case ($urandom_range(3))
			0: return 64'd0;
			1: return 64'(NVARS - 1);
			default: return 64'($urandom_range(NVARS - 1));
		endcase
	endfunction

	// arithmetic wrap, truncating division, comparisons
	task automatic test_arith();
		send_insn(OP_PUSH, MAXV);
		send_insn(OP_PUSH, 64'd1);
		send_insn(OP_ADD, 64'd0);
		send_insn(OP_PUSH, MINV);
		send_insn(OP_PUSH, 64'hffff_ffff_ffff_ffff);
		send_insn(OP_DIV, 64'd0);
		send_insn(OP_PUSH, 64'hffff_ffff_ffff_fff9);
		send_insn(OP_PUSH, 64'd2);
		send_insn(OP_MOD, 64'd0);
		send_insn(OP_SUB, 64'd0);
		send_insn(OP_GT, 64'd0);
		send_insn(OP_PUSH, 64'hffff_ffff_ffff_fffb);
		send_insn(OP_LT, 64'd0);
		send_insn(OP_PUSH, 64'd0);
		send_insn(OP_EQ, 64'd0);
		send_insn(OP_NEG, 64'd0);
		send_insn(OP_PUSH, 64'd3);
		send_insn(OP_MUL, 64'd0);
	endtask

	// variable store at both ends, jumps with wrap, print, unknown opcodes
	task automatic test_store_flow();
		send_insn(OP_STORE, 64'(NVARS - 1));
		send_insn(OP_LOAD, 64'(NVARS - 1));
		send_insn(OP_JT, 64'd100);
		send_insn(OP_LOAD, 64'd0);
		send_insn(OP_JF, 64'hffff);
		send_insn(OP_JMP, 64'hffff_ffff_ffff_ffff);
		send_insn(OP_PUSH, 64'd5);
		send_insn(OP_PRINT, 64'd0);
		send_insn(8'hff, MAXV);
	endtask

	// random programs that never fault
	task automatic test_random(input int count);
		logic [7:0] f;
		int r;
		for (int n = 0; n < count; n++) begin
			send_idle = (n >= count / 3 && n < count / 2) ? 0 : 35;
			recv_idle = send_idle;
			r = $urandom_range(99);
			if (m_sp > 64 && r < 30) r = 30 + $urandom_range(69);
			if (r < 30) f = OP_PUSH;
			else if (r < 50) f = 8'($urandom_range(2, 5) + ($urandom_range(2) == 0 ? 0 : 0));
			else if (r < 58) f = ($urandom_range(1)) ? OP_GT : OP_LT;
			else if (r < 62) f = ($urandom_range(1)) ? OP_MOD : OP_EQ;
			else if (r < 70) f = ($urandom_range(1)) ? OP_STORE : OP_LOAD;
			else if (r < 76) f = OP_PRINT;
			else if (r < 80) f = OP_NEG;
			else if (r < 88) f = 8'($urandom_range(OP_JT, OP_JMP));
			else f = 8'($urandom_range(17, 255));
			// replace anything that would fault with a push
			case (f)
				OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_LT, OP_EQ:
					if (m_sp < 2) f = OP_PUSH;
				OP_DIV, OP_MOD:
					if (m_sp < 2 || m_stack[m_sp-1] == 0) f = OP_PUSH;
				OP_STORE, OP_PRINT, OP_NEG, OP_JT, OP_JF:
					if (m_sp < 1) f = OP_PUSH;
				default: ;
			endcase
			if (f == OP_STORE || f == OP_LOAD) send_insn(f, rand_var());
			else if (f == OP_PUSH) send_insn(f, rand_value());
			else send_insn(f, {$urandom, $urandom});
		end
		send_idle = 35;
		recv_idle = 35;
	endtask

	// one halting case picked at random, then words that must be ignored
	task automatic test_halt();
		case ($urandom_range(6))
			0: send_insn(OP_END, {$urandom, $urandom});
			1: begin
				while (m_sp > 0) send_insn(OP_PRINT, 64'd0);
				send_insn(($urandom_range(1)) ? OP_ADD : OP_STORE, 64'd0);
			end
			2: begin
				send_idle = 0;
				while (m_sp < DEPTH) send_insn(OP_PUSH, rand_value());
				send_idle = 35;
				send_insn(($urandom_range(1)) ? OP_PUSH : OP_LOAD, 64'd3);
			end
			3: begin
				send_insn(OP_PUSH, 64'd1);
				send_insn(OP_PUSH, 64'd0);
				send_insn(($urandom_range(1)) ? OP_DIV : OP_MOD, 64'd0);
			end
			4: begin
				send_insn(OP_PUSH, 64'd1);
				send_insn(OP_STORE, ($urandom_range(1)) ? 64'(NVARS) : MINV);
			end
			5: send_insn(OP_LOAD, ($urandom_range(1)) ? 64'(NVARS) : 64'hffff_ffff_ffff_ffff);
			default: begin
				while (m_sp > 0) send_insn(OP_PRINT, 64'd0);
				send_insn(($urandom_range(1)) ? OP_PRINT : OP_JT, 64'd0);
			end
		endcase
		for (int n = 0; n < 6; n++) send_insn(8'($urandom_range(0, 16)), rand_value());
	endtask

	initial begin
		for (int n = 0; n < NVARS; n++) m_vars[n] = 64'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_arith();
		test_store_flow();
		test_random(600);
		test_halt();
		item_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("stack_machine_execute_unit test passed");
		else
			$display("stack_machine_execute_unit test failed");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("stack_machine_execute_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
